// ===== rtl/pcth_pkg.sv =====
// Package: types, constants and field offsets shared by the capture header parser.
package pcth_pkg;

  // Capture file framing.
  localparam int unsigned FileHdrBytes   = 24;
  localparam int unsigned TimestampBytes = 8;

  // Body offsets of the captured fields.
  localparam logic [31:0] OffMacSrc  = 32'd6;
  localparam logic [31:0] OffEther   = 32'd12;
  localparam logic [31:0] OffEtherLo = 32'd13;
  localparam logic [31:0] OffVerIhl  = 32'd14;
  localparam logic [31:0] OffTotal   = 32'd16;
  localparam logic [31:0] OffTotalLo = 32'd17;
  localparam logic [31:0] OffProto   = 32'd23;
  localparam logic [31:0] OffIpSrc   = 32'd26;
  localparam logic [31:0] OffIpDst   = 32'd30;
  localparam logic [31:0] OffPorts   = 32'd34;
  localparam logic [31:0] OffSeq     = 32'd38;
  localparam logic [31:0] OffSeqEnd  = 32'd42;
  localparam logic [31:0] TcpOffPos  = 32'd46;

  // Protocol constants.
  localparam logic [15:0] EtherIpv4  = 16'h0800;
  localparam logic [15:0] EtherIpv6  = 16'h86DD;
  localparam logic [3:0]  IpVersion4 = 4'd4;
  localparam logic [3:0]  IpIhlMin   = 4'd5;
  localparam logic [15:0] IpMinTotal = 16'd20;
  localparam logic [7:0]  ProtoTcp   = 8'd6;

  typedef enum logic [2:0] {
    PH_FILE = 3'b001,
    PH_REC  = 3'b010,
    PH_BODY = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_LEN_MISMATCH = 3'd1,
    ST_BAD_ETHER    = 3'd2,
    ST_BAD_IPHDR    = 3'd3,
    ST_SHORT_TOTAL  = 3'd4,
    ST_NOT_TCP      = 3'd5,
    ST_TRUNCATED    = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] captured_len;
    logic [47:0] mac_dest;
    logic [47:0] mac_source;
    logic [15:0] ether_kind;
    logic [15:0] ip_total_length;
    logic [31:0] ip_source;
    logic [31:0] ip_dest;
    logic [15:0] port_source;
    logic [15:0] port_dest;
    logic [31:0] sequence_number;
    logic [3:0]  tcp_header_words;
    status_e     status;
  } res_t;

endpackage

// ===== rtl/pcth_stream_if.sv =====
// Interfaces: the byte input channel and the header result channel.
interface pcth_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pcth_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] captured_len;
  logic [47:0] mac_dest;
  logic [47:0] mac_source;
  logic [15:0] ether_kind;
  logic [15:0] ip_total_length;
  logic [31:0] ip_source;
  logic [31:0] ip_dest;
  logic [15:0] port_source;
  logic [15:0] port_dest;
  logic [31:0] sequence_number;
  logic [3:0]  tcp_header_words;
  logic [2:0]  status;

  modport source (
    output valid, output captured_len, output mac_dest, output mac_source,
    output ether_kind, output ip_total_length, output ip_source, output ip_dest,
    output port_source, output port_dest, output sequence_number,
    output tcp_header_words, output status, input ready
  );
  modport sink (
    input valid, input captured_len, input mac_dest, input mac_source,
    input ether_kind, input ip_total_length, input ip_source, input ip_dest,
    input port_source, input port_dest, input sequence_number,
    input tcp_header_words, input status, output ready
  );
endinterface

// ===== rtl/pcth_parser.sv =====
// Parser core: stream position tracking, field capture and result formation.
module pcth_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_i,
  output logic                res_valid_o,
  output pcth_pkg::res_t      res_o
);
  import pcth_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] rec_len_q, rec_len_d;
  logic [31:0] orig_len_q, orig_len_d;
  logic [47:0] mac_dst_q, mac_dst_d;
  logic [47:0] mac_src_q, mac_src_d;
  logic [15:0] ether_q, ether_d;
  logic [15:0] total_q, total_d;
  logic [31:0] ip_src_q, ip_src_d;
  logic [31:0] ip_dst_q, ip_dst_d;
  logic [31:0] ports_q, ports_d;
  logic [31:0] seq_q, seq_d;
  status_e     err_q, err_d;
  logic        emitted_q, emitted_d;

  logic [31:0] pos_inc;
  logic [31:0] rel;
  logic        clear_rec;
  logic        emit;
  logic [3:0]  emit_words;
  status_e     emit_status;

  assign pos_inc = pos_q + 32'd1;
  assign rel     = pos_q - 32'(TimestampBytes);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    rec_len_d   = rec_len_q;
    orig_len_d  = orig_len_q;
    mac_dst_d   = mac_dst_q;
    mac_src_d   = mac_src_q;
    ether_d     = ether_q;
    total_d     = total_q;
    ip_src_d    = ip_src_q;
    ip_dst_d    = ip_dst_q;
    ports_d     = ports_q;
    seq_d       = seq_q;
    err_d       = err_q;
    emitted_d   = emitted_q;
    clear_rec   = 1'b0;
    emit        = 1'b0;
    emit_words  = 4'd0;
    emit_status = ST_OK;

    if (take_i) begin
      unique case (phase_q)
        PH_FILE: begin
          pos_d = pos_inc;
          if (pos_inc >= 32'(FileHdrBytes)) begin
            clear_rec = 1'b1;
          end
        end
        PH_REC: begin
          // Both lengths arrive little-endian after the timestamp.
          if (pos_q >= 32'(TimestampBytes) && pos_q < 32'(TimestampBytes + 4)) begin
            rec_len_d = rec_len_q | ({24'd0, byte_i} << {rel[1:0], 3'b000});
          end else if (pos_q >= 32'(TimestampBytes + 4) &&
                       pos_q < 32'(TimestampBytes + 8)) begin
            orig_len_d = orig_len_q | ({24'd0, byte_i} << {rel[1:0], 3'b000});
          end
          pos_d = pos_inc;
          if (pos_inc >= 32'(TimestampBytes + 8)) begin
            phase_d = PH_BODY;
            pos_d   = 32'd0;
            if (rec_len_d != orig_len_d && err_d == ST_OK) begin
              err_d = ST_LEN_MISMATCH;
            end
            if (rec_len_d == 32'd0) begin
              emit        = 1'b1;
              emit_status = (err_d != ST_OK) ? err_d : ST_TRUNCATED;
              clear_rec   = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if (!emitted_q) begin
            priority if (pos_q < OffMacSrc) begin
              mac_dst_d = {mac_dst_q[39:0], byte_i};
            end else if (pos_q < OffEther) begin
              mac_src_d = {mac_src_q[39:0], byte_i};
            end else if (pos_q <= OffEtherLo) begin
              ether_d = {ether_q[7:0], byte_i};
              if (pos_q == OffEtherLo && ether_d != EtherIpv4 && ether_d != EtherIpv6 &&
                  err_d == ST_OK) begin
                err_d = ST_BAD_ETHER;
              end
            end else if (pos_q == OffVerIhl) begin
              if ((byte_i[7:4] != IpVersion4 || byte_i[3:0] != IpIhlMin) &&
                  err_d == ST_OK) begin
                err_d = ST_BAD_IPHDR;
              end
            end else if (pos_q == OffTotal || pos_q == OffTotalLo) begin
              total_d = {total_q[7:0], byte_i};
              if (pos_q == OffTotalLo && total_d < IpMinTotal && err_d == ST_OK) begin
                err_d = ST_SHORT_TOTAL;
              end
            end else if (pos_q == OffProto) begin
              if (byte_i != ProtoTcp && err_d == ST_OK) begin
                err_d = ST_NOT_TCP;
              end
            end else if (pos_q >= OffIpSrc && pos_q < OffIpDst) begin
              ip_src_d = {ip_src_q[23:0], byte_i};
            end else if (pos_q >= OffIpDst && pos_q < OffPorts) begin
              ip_dst_d = {ip_dst_q[23:0], byte_i};
            end else if (pos_q >= OffPorts && pos_q < OffSeq) begin
              ports_d = {ports_q[23:0], byte_i};
            end else if (pos_q >= OffSeq && pos_q < OffSeqEnd) begin
              seq_d = {seq_q[23:0], byte_i};
            end else begin
              // Bytes between the captured fields carry nothing we keep.
            end
            if (pos_q == TcpOffPos) begin
              emit        = 1'b1;
              emit_words  = byte_i[7:4];
              emit_status = err_d;
              emitted_d   = 1'b1;
            end
          end
          // The position compare is one bit wider so the last possible byte still ends it.
          if ({1'b0, pos_q} + 33'd1 >= {1'b0, rec_len_q}) begin
            if (!emitted_d) begin
              emit        = 1'b1;
              emit_status = (err_d != ST_OK) ? err_d : ST_TRUNCATED;
            end
            clear_rec = 1'b1;
          end else begin
            pos_d = pos_inc;
          end
        end
        default: begin
          clear_rec = 1'b1;
        end
      endcase
    end

    res_o.captured_len     = rec_len_d;
    res_o.mac_dest         = mac_dst_d;
    res_o.mac_source       = mac_src_d;
    res_o.ether_kind       = ether_d;
    res_o.ip_total_length  = total_d;
    res_o.ip_source        = ip_src_d;
    res_o.ip_dest          = ip_dst_d;
    res_o.port_source      = ports_d[31:16];
    res_o.port_dest        = ports_d[15:0];
    res_o.sequence_number  = seq_d;
    res_o.tcp_header_words = emit_words;
    res_o.status           = emit_status;
    res_valid_o            = emit;

    if (clear_rec) begin
      phase_d    = PH_REC;
      pos_d      = 32'd0;
      rec_len_d  = 32'd0;
      orig_len_d = 32'd0;
      mac_dst_d  = 48'd0;
      mac_src_d  = 48'd0;
      ether_d    = 16'd0;
      total_d    = 16'd0;
      ip_src_d   = 32'd0;
      ip_dst_d   = 32'd0;
      ports_d    = 32'd0;
      seq_d      = 32'd0;
      err_d      = ST_OK;
      emitted_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= (FileHdrBytes > 0) ? PH_FILE : PH_REC;
      pos_q      <= 32'd0;
      rec_len_q  <= 32'd0;
      orig_len_q <= 32'd0;
      mac_dst_q  <= 48'd0;
      mac_src_q  <= 48'd0;
      ether_q    <= 16'd0;
      total_q    <= 16'd0;
      ip_src_q   <= 32'd0;
      ip_dst_q   <= 32'd0;
      ports_q    <= 32'd0;
      seq_q      <= 32'd0;
      err_q      <= ST_OK;
      emitted_q  <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rec_len_q  <= rec_len_d;
      orig_len_q <= orig_len_d;
      mac_dst_q  <= mac_dst_d;
      mac_src_q  <= mac_src_d;
      ether_q    <= ether_d;
      total_q    <= total_d;
      ip_src_q   <= ip_src_d;
      ip_dst_q   <= ip_dst_d;
      ports_q    <= ports_d;
      seq_q      <= seq_d;
      err_q      <= err_d;
      emitted_q  <= emitted_d;
    end
  end

endmodule

// ===== rtl/pcth_tcp_header_extractor_unit_dummy_guard.sv =====
// Output stage: holds one finished header result until the sink takes it.
module pcth_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  pcth_pkg::res_t res_i,
  input  logic           take_i,
  output logic           valid_o,
  output pcth_pkg::res_t res_o
);
  import pcth_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  // A load and a take in the same cycle keep the stage full with the new item.
  assign valid_d = load_i | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/pcap_tcp_header_extractor_unit.sv =====
// Top level: capture-stream Ethernet/IPv4/TCP header extractor.
//
//   channel  direction  payload                                   moves
//   in_i     sink       data_byte (8)                             one byte of the capture file
//   out_o    source     captured_len .. status (header fields)    one result per record
//
// Each accepted byte is handled in the cycle it is taken; a record that yields a result
// has it on out_o in the cycle after the byte that completes it (body byte 46, or the last
// byte of a shorter record). The sustained rate is one byte per cycle, set by the single
// output register: in_i stays ready while that register is empty or being drained.
// Reset is asynchronous and active low; it puts the parser back at the file header.
// A stall on out_o holds the waiting result and stops intake only while it lasts.
module pcap_tcp_header_extractor_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcth_in_if.sink    in_i,
  pcth_out_if.source out_o
);
  import pcth_pkg::*;

  logic accept;
  logic res_valid;
  res_t res_new;
  logic out_valid;
  res_t out_res;

  // A new byte may enter whenever the output register is free or is being emptied now,
  // so a finished result blocks the byte that follows it only while the sink stalls it.
  assign in_i.ready = ~out_valid | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  // The parser walks the file header, the record header and the body, and forms a
  // result combinationally on the byte that completes a record's header fields or ends it.
  pcth_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (accept),
    .byte_i      (in_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  // The output register parts the two handshakes.
  pcth_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res_new),
    .take_i  (out_o.ready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign out_o.valid            = out_valid;
  assign out_o.captured_len     = out_res.captured_len;
  assign out_o.mac_dest         = out_res.mac_dest;
  assign out_o.mac_source       = out_res.mac_source;
  assign out_o.ether_kind       = out_res.ether_kind;
  assign out_o.ip_total_length  = out_res.ip_total_length;
  assign out_o.ip_source        = out_res.ip_source;
  assign out_o.ip_dest          = out_res.ip_dest;
  assign out_o.port_source      = out_res.port_source;
  assign out_o.port_dest        = out_res.port_dest;
  assign out_o.sequence_number  = out_res.sequence_number;
  assign out_o.tcp_header_words = out_res.tcp_header_words;
  assign out_o.status           = out_res.status;

  // A waiting result that is not taken must stop intake, or it could be overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_o.ready |-> !in_i.ready)
    else $error("byte intake open while a result is stalled");

  // The parser only produces a result on a byte that is actually accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> !res_valid)
    else $error("result formed without an accepted byte");

  // A result loaded by an accepted byte shows up on the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid |=> out_valid)
    else $error("result lost in the output register");

  // A truncated record never reaches the data offset byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_o.status == ST_TRUNCATED |-> out_o.tcp_header_words == 4'd0)
    else $error("truncated result carries a data offset");

  // An empty record can never report a clean status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_o.captured_len == 32'd0 |-> out_o.status != ST_OK)
    else $error("empty record reported as ok");

endmodule
